@@ rtl/core/fdh_pkg.sv @@
package fdh_pkg;

  localparam int unsigned BIN_COUNT_DEF    = 33;
  localparam int unsigned MAX_FRAME_PIXELS = 524288;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned COUNT_W   = 20;
  localparam int unsigned BIN_IDX_W = 6;

  localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] SAT_LIMIT =
      COUNT_W'((MAX_FRAME_PIXELS < COUNT_MAX) ? MAX_FRAME_PIXELS : COUNT_MAX);

  localparam logic [PIX_W-1:0] SHADE_ZERO = 8'd255;
  localparam logic [PIX_W-1:0] SHADE_BASE = 8'd32;
  localparam logic [PIX_W-1:0] SHADE_GAIN = 8'd7;

  // result kind carried on m_tuser
  localparam logic KIND_SHADE = 1'b0;
  localparam logic KIND_BIN   = 1'b1;

  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned M_DATA_W = 40;

endpackage

@@ rtl/core/frame_diff_histogram_core.sv @@
// A pixel's shade transfer passes through stage 1 and then the output register.
// Throughput: 1 pixel pair per cycle unless stalled, set by one read-modify-write pass with forwarding.
// A frame_end pixel starts a readout of all BIN_COUNT bins through the same memory port,
//   during which s_tready is low; output stalls hold the whole pipeline.
// Reset (rst, synchronous): clears control and the per-bin valid bits, so every
//   bin reads as zero at once; no clearing pass.
module frame_diff_histogram_core #(
  parameter int unsigned BIN_COUNT = fdh_pkg::BIN_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [fdh_pkg::S_DATA_W-1:0]  s_tdata,  // pixel_a[7:0], pixel_b[15:8]
  input  logic                          s_tlast,  // frame_end
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [fdh_pkg::M_DATA_W-1:0]  m_tdata,  // shade[7:0], bin_index[13:8],
                                                  // bin_count[33:14], zero fill
  output logic                          m_tuser,  // result_kind
  output logic                          m_tlast   // run_last
);
  import fdh_pkg::*;

  localparam int unsigned IDX_W = $clog2(BIN_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BIN_COUNT - 1);

  // bin memory
  logic [COUNT_W-1:0] mem [BIN_COUNT];
  logic [COUNT_W-1:0] mem_q;
  logic [BIN_COUNT-1:0] vld;
  logic               vld_q;

  // stage 1 (memory read in flight)
  logic             s1_valid;
  logic             s1_bin;
  logic [IDX_W-1:0] s1_addr;
  logic             s1_run_last;
  logic             s1_cnt_ok;
  logic [PIX_W-1:0] s1_shade;

  // readout sequencer
  logic             gen_busy;
  logic [IDX_W-1:0] gen_idx;

  // previous write, for forwarding
  logic               wr_valid_q;
  logic [IDX_W-1:0]   wr_addr_q;
  logic [COUNT_W-1:0] wr_data_q;

  // output register
  logic [PIX_W-1:0]     out_shade;
  logic [BIN_IDX_W-1:0] out_idx;
  logic [COUNT_W-1:0]   out_count;

  logic               adv;
  logic               in_fire;
  logic [PIX_W-1:0]   pix_a;
  logic [PIX_W-1:0]   pix_b;
  logic [PIX_W-1:0]   diff;
  logic               in_cnt_ok;
  logic [PIX_W-1:0]   in_shade;
  logic [IDX_W-1:0]   rd_addr;
  logic [COUNT_W-1:0] cur;
  logic               wr_en;
  logic [COUNT_W-1:0] wr_data;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !gen_busy;
  assign in_fire  = s_tvalid && s_tready;

  assign pix_a     = s_tdata[PIX_W-1:0];
  assign pix_b     = s_tdata[2*PIX_W-1:PIX_W];
  assign diff      = (pix_a > pix_b) ? (pix_a - pix_b) : (pix_b - pix_a);
  assign in_cnt_ok = (9'(diff) < 9'(BIN_COUNT));
  assign in_shade  = (diff == '0) ? SHADE_ZERO : 8'((SHADE_BASE - diff) * SHADE_GAIN);

  // re-read the held entry while stalled so the read data stays current
  always_comb begin
    if (!adv) begin
      rd_addr = s1_addr;
    end else if (gen_busy) begin
      rd_addr = gen_idx;
    end else begin
      rd_addr = IDX_W'(diff);
    end
  end

  always_comb begin
    if (wr_valid_q && (wr_addr_q == s1_addr)) begin
      cur = wr_data_q;
    end else if (vld_q) begin
      cur = mem_q;
    end else begin
      cur = '0;
    end
  end

  assign wr_en   = adv && s1_valid && (s1_bin || s1_cnt_ok);
  assign wr_data = s1_bin ? '0 : ((cur >= SAT_LIMIT) ? cur : cur + 1'b1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_q <= vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid_q <= 1'b0;
    end else begin
      wr_valid_q <= wr_en;
    end
    wr_addr_q <= s1_addr;
    wr_data_q <= wr_data;
  end

  // readout sequencer and stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_busy <= 1'b0;
      gen_idx  <= '0;
      s1_valid <= 1'b0;
    end else if (adv) begin
      if (gen_busy) begin
        s1_valid    <= 1'b1;
        s1_bin      <= 1'b1;
        s1_addr     <= gen_idx;
        s1_run_last <= (gen_idx == LAST_IDX);
        s1_cnt_ok   <= 1'b0;
        s1_shade    <= '0;
        if (gen_idx == LAST_IDX) begin
          gen_busy <= 1'b0;
          gen_idx  <= '0;
        end else begin
          gen_idx <= gen_idx + 1'b1;
        end
      end else if (in_fire) begin
        s1_valid    <= 1'b1;
        s1_bin      <= 1'b0;
        s1_addr     <= IDX_W'(diff);
        s1_run_last <= !s_tlast;
        s1_cnt_ok   <= in_cnt_ok;
        s1_shade    <= in_shade;
        if (s_tlast) begin
          gen_busy <= 1'b1;
          gen_idx  <= '0;
        end
      end else begin
        s1_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s1_valid;
    end
    if (adv) begin
      m_tuser   <= s1_bin ? KIND_BIN : KIND_SHADE;
      m_tlast   <= s1_run_last;
      out_shade <= s1_bin ? '0 : s1_shade;
      out_idx   <= s1_bin ? BIN_IDX_W'(s1_addr) : '0;
      out_count <= s1_bin ? cur : '0;
    end
  end

  assign m_tdata = {(M_DATA_W - PIX_W - BIN_IDX_W - COUNT_W)'(0), out_count, out_idx,
                    out_shade};

endmodule

@@ rtl/core/fdh_checker.sv @@
module fdh_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         s_tlast,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [fdh_pkg::M_DATA_W-1:0] m_tdata,
  input logic                         m_tuser,
  input logic                         m_tlast
);
  import fdh_pkg::*;

  // stalled output transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("stalled output transfer changed");

  // a frame_end pixel starts the readout, so no input follows at once
  a_readout_block: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input taken right after frame end");

  a_shade_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_SHADE)) |-> (m_tdata[M_DATA_W-1:PIX_W] == '0))
    else $error("shade result carries bin fields");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_BIN)) |->
      (m_tdata[PIX_W+BIN_IDX_W+COUNT_W-1:PIX_W+BIN_IDX_W] <= SAT_LIMIT))
    else $error("bin count above saturation limit");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind frame_diff_histogram_core fdh_checker u_fdh_checker (.*);
